// File: rtl/modexp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// modexp_pkg
// Shared types and constants of the modular exponentiation unit.
// ----------------------------------------------------------------------------
package modexp_pkg;

   // width of every payload port, independent of the datapath width
   localparam int FIELD_WIDTH = 32;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RED_ISSUE,
      ST_RED_RUN,
      ST_SQ_ISSUE,
      ST_SQ_RUN,
      ST_MUL_ISSUE,
      ST_MUL_RUN,
      ST_FINISH
   } state_type;

   // request to the serial modular multiplier
   typedef struct packed {
      logic start;
      logic reduce;
   } mm_req_type;

endpackage
`default_nettype wire

// File: rtl/modexp_mulmod.sv
`default_nettype none
// ----------------------------------------------------------------------------
// modexp_mulmod
// Bit-serial modular multiplier. Scans operand_b from its top bit, one bit a
// cycle: r = 2r mod m, then r = r + a mod m for a set bit. In reduce mode the
// bit of operand_b is shifted into r instead, giving operand_b mod m.
// ----------------------------------------------------------------------------
module modexp_mulmod
   import modexp_pkg::*;
#(
   parameter int OPERAND_WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  mm_req_type               req,
   input  logic [OPERAND_WIDTH-1:0] operand_a,
   input  logic [OPERAND_WIDTH-1:0] operand_b,
   input  logic [OPERAND_WIDTH-1:0] modulus,
   output logic                     done,
   output logic [OPERAND_WIDTH-1:0] product
);

   localparam int CW = $clog2(OPERAND_WIDTH);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic                     reduce_ff, reduce_in;
   logic [CW-1:0]            cnt_ff, cnt_in;
   logic [OPERAND_WIDTH-1:0] r_ff, r_in;
   logic [OPERAND_WIDTH-1:0] a_ff, a_in;
   logic [OPERAND_WIDTH-1:0] b_ff, b_in;
   logic [OPERAND_WIDTH-1:0] m_ff, m_in;

   logic                     bit_in;
   logic [OPERAND_WIDTH:0]   dbl;
   logic [OPERAND_WIDTH:0]   dbl_red;
   logic [OPERAND_WIDTH-1:0] addend;
   logic [OPERAND_WIDTH:0]   sum;
   logic [OPERAND_WIDTH:0]   sum_red;

   always_comb begin
      bit_in  = reduce_ff & b_ff[OPERAND_WIDTH-1];
      dbl     = {r_ff, bit_in};
      dbl_red = (dbl >= {1'b0, m_ff}) ? (dbl - {1'b0, m_ff}) : dbl;
      addend  = (!reduce_ff && b_ff[OPERAND_WIDTH-1]) ? a_ff : '0;
      sum     = {1'b0, dbl_red[OPERAND_WIDTH-1:0]} + {1'b0, addend};
      sum_red = (sum >= {1'b0, m_ff}) ? (sum - {1'b0, m_ff}) : sum;
   end

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      reduce_in = reduce_ff;
      cnt_in    = cnt_ff;
      r_in      = r_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      m_in      = m_ff;
      if (req.start) begin
         busy_in   = 1'b1;
         reduce_in = req.reduce;
         cnt_in    = CW'(OPERAND_WIDTH - 1);
         r_in      = '0;
         a_in      = operand_a;
         b_in      = operand_b;
         m_in      = modulus;
      end else if (busy_ff) begin
         r_in   = sum_red[OPERAND_WIDTH-1:0];
         b_in   = b_ff << 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      reduce_ff <= reduce_in;
      cnt_ff    <= cnt_in;
      r_ff      <= r_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      m_ff      <= m_in;
   end

   assign done    = done_ff;
   assign product = r_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      req.start |-> !busy_ff)
      else $error("multiplier started while busy");

   a_residue_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (r_ff < m_ff))
      else $error("partial residue not below modulus");

   a_residue_done: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (!busy_ff && (r_ff < m_ff)))
      else $error("product not reduced at done");

endmodule
`default_nettype wire

// File: rtl/modular_exponentiation_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// modular_exponentiation_unit
// Computes base ** exponent mod modulus by left-to-right square and multiply.
// ----------------------------------------------------------------------------
// Usage:
//   req carries base, exponent and modulus as one word; rsp returns the power
//   and a bad_modulus flag, one rsp word per req word.
//   A zero modulus gives bad_modulus = 1 and a power of 0; a zero exponent
//   gives 1. For both, the word goes straight from idle to ST_FINISH.
//   Otherwise the base is first reduced, then each of the OPERAND_WIDTH
//   exponent bits costs one modular square, and a set bit one more multiply,
//   each run on one bit-serial multiplier.
//   One word is in flight; req_ready is high only when idle, so the next word
//   can be taken in the cycle after a result is loaded.
//   A finished result waits in the output register while rsp stalls, and a
//   new word is taken meanwhile; the next result waits for rsp_ready.
//   Synchronous reset empties the output register and returns to idle.
// ----------------------------------------------------------------------------
module modular_exponentiation_unit
   import modexp_pkg::*;
#(
   parameter int OPERAND_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [FIELD_WIDTH-1:0] req_base_value,
   input  logic [FIELD_WIDTH-1:0] req_exponent_value,
   input  logic [FIELD_WIDTH-1:0] req_modulus_value,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [FIELD_WIDTH-1:0] rsp_power_result,
   output logic                   rsp_bad_modulus
);

   localparam int CW = $clog2(OPERAND_WIDTH);

   state_type                state_ff, state_in;
   logic [OPERAND_WIDTH-1:0] base_ff, base_in;
   logic [OPERAND_WIDTH-1:0] exp_ff, exp_in;
   logic [OPERAND_WIDTH-1:0] mod_ff, mod_in;
   logic [OPERAND_WIDTH-1:0] acc_ff, acc_in;
   logic                     bad_ff, bad_in;
   logic [CW-1:0]            bit_cnt_ff, bit_cnt_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [FIELD_WIDTH-1:0]   rsp_power_ff, rsp_power_in;
   logic                     rsp_bad_ff, rsp_bad_in;

   logic [OPERAND_WIDTH-1:0] base_w, exp_w, mod_w;
   logic                     accept;
   logic                     advance;
   logic                     load_rsp;
   mm_req_type               mm_req;
   logic [OPERAND_WIDTH-1:0] mm_b;
   logic                     mm_done;
   logic [OPERAND_WIDTH-1:0] mm_product;

   assign base_w = OPERAND_WIDTH'(req_base_value);
   assign exp_w  = OPERAND_WIDTH'(req_exponent_value);
   assign mod_w  = OPERAND_WIDTH'(req_modulus_value);

   // control outputs
   always_comb begin
      req_ready     = (state_ff == ST_IDLE);
      accept        = req_ready && req_valid;
      mm_req.start  = (state_ff == ST_RED_ISSUE) || (state_ff == ST_SQ_ISSUE) ||
                      (state_ff == ST_MUL_ISSUE);
      mm_req.reduce = (state_ff == ST_RED_ISSUE);
      mm_b          = (state_ff == ST_SQ_ISSUE) ? acc_ff : base_ff;
      // end of one exponent bit
      advance       = mm_done &&
                      (((state_ff == ST_SQ_RUN) && !exp_ff[OPERAND_WIDTH-1]) ||
                       (state_ff == ST_MUL_RUN));
      load_rsp      = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if ((mod_w == '0) || (exp_w == '0)) state_in = ST_FINISH;
               else                                 state_in = ST_RED_ISSUE;
            end
         end
         ST_RED_ISSUE: state_in = ST_RED_RUN;
         ST_RED_RUN: begin
            if (mm_done) state_in = ST_SQ_ISSUE;
         end
         ST_SQ_ISSUE: state_in = ST_SQ_RUN;
         ST_SQ_RUN: begin
            if (advance) state_in = (bit_cnt_ff == '0) ? ST_FINISH : ST_SQ_ISSUE;
            else if (mm_done) state_in = ST_MUL_ISSUE;
         end
         ST_MUL_ISSUE: state_in = ST_MUL_RUN;
         ST_MUL_RUN: begin
            if (advance) state_in = (bit_cnt_ff == '0) ? ST_FINISH : ST_SQ_ISSUE;
         end
         ST_FINISH: begin
            if (load_rsp) state_in = ST_IDLE;
         end
      endcase
   end

   // datapath
   always_comb begin
      base_in      = base_ff;
      exp_in       = exp_ff;
      mod_in       = mod_ff;
      acc_in       = acc_ff;
      bad_in       = bad_ff;
      bit_cnt_in   = bit_cnt_ff;
      rsp_power_in = rsp_power_ff;
      rsp_bad_in   = rsp_bad_ff;
      rsp_valid_in = rsp_valid_ff;

      if (accept) begin
         base_in    = base_w;
         exp_in     = exp_w;
         mod_in     = mod_w;
         bit_cnt_in = CW'(OPERAND_WIDTH - 1);
         bad_in     = (mod_w == '0);
         priority if (mod_w == '0) acc_in = '0;
         else if (exp_w == '0)     acc_in = OPERAND_WIDTH'(1);
         else if (mod_w == OPERAND_WIDTH'(1)) acc_in = '0;
         else                      acc_in = OPERAND_WIDTH'(1);
      end

      if ((state_ff == ST_RED_RUN) && mm_done) base_in = mm_product;
      if (((state_ff == ST_SQ_RUN) || (state_ff == ST_MUL_RUN)) && mm_done) begin
         acc_in = mm_product;
      end
      if (advance) begin
         exp_in     = exp_ff << 1;
         bit_cnt_in = bit_cnt_ff - 1'b1;
      end

      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_power_in = FIELD_WIDTH'(acc_ff);
         rsp_bad_in   = bad_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff      <= base_in;
      exp_ff       <= exp_in;
      mod_ff       <= mod_in;
      acc_ff       <= acc_in;
      bad_ff       <= bad_in;
      bit_cnt_ff   <= bit_cnt_in;
      rsp_power_ff <= rsp_power_in;
      rsp_bad_ff   <= rsp_bad_in;
   end

   modexp_mulmod #(
      .OPERAND_WIDTH(OPERAND_WIDTH)
   ) u_mulmod (
      .clock     (clock),
      .reset     (reset),
      .req       (mm_req),
      .operand_a (acc_ff),
      .operand_b (mm_b),
      .modulus   (mod_ff),
      .done      (mm_done),
      .product   (mm_product)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_power_result = rsp_power_ff;
   assign rsp_bad_modulus  = rsp_bad_ff;

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_bad_ff) |-> (rsp_power_ff == '0))
      else $error("bad modulus word with nonzero power");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != ST_IDLE))
      else $error("still idle after accepting a word");

   a_finish_load: assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> (rsp_valid_ff && (state_ff == ST_IDLE)))
      else $error("result not presented after finish");

   a_done_in_run: assert property (@(posedge clock) disable iff (reset)
      mm_done |-> ((state_ff == ST_RED_RUN) || (state_ff == ST_SQ_RUN) ||
                   (state_ff == ST_MUL_RUN)))
      else $error("multiplier done outside a run state");

endmodule
`default_nettype wire

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the modular exponentiation unit: directed corner
// words, a back-pressure phase, then random words, each response compared
// against an in-bench power predictor.
// ----------------------------------------------------------------------------
module tb_top;
   import modexp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HOLD_OFF_CYCLES = 3000;
   localparam int SETTLE_CYCLES   = 2300;
   localparam int RANDOM_WORDS    = 256;
   localparam int CALM_WORDS      = 40;

   typedef struct packed {
      logic [FIELD_WIDTH-1:0] power;
      logic                   bad;
   } power_word_type;

   class power_scoreboard;
      power_word_type expected_powers[$];
      int unsigned    error_count;

      function new();
         error_count = 0;
      endfunction

      // base ** exponent mod modulus; 64-bit products never overflow here
      function power_word_type predict_power(input logic [FIELD_WIDTH-1:0] base_in,
                                             input logic [FIELD_WIDTH-1:0] exp_in,
                                             input logic [FIELD_WIDTH-1:0] mod_in);
         power_word_type   word;
         longint unsigned  acc;
         longint unsigned  reduced_base;
         longint unsigned  modulus;
         int               i;
         word.bad = 1'b0;
         if (mod_in == '0) begin
            word.power = '0;
            word.bad   = 1'b1;
         end else if (exp_in == '0) begin
            word.power = 1;
         end else begin
            modulus      = 64'(mod_in);
            reduced_base = 64'(base_in) % modulus;
            acc          = 64'd1 % modulus;
            for (i = FIELD_WIDTH - 1; i >= 0; i--) begin
               acc = (acc * acc) % modulus;
               if (exp_in[i])
                  acc = (acc * reduced_base) % modulus;
            end
            word.power = acc[FIELD_WIDTH-1:0];
         end
         return word;
      endfunction

      function void note_request(input logic [FIELD_WIDTH-1:0] base_in,
                                 input logic [FIELD_WIDTH-1:0] exp_in,
                                 input logic [FIELD_WIDTH-1:0] mod_in);
         power_word_type want;
         want            = predict_power(base_in, exp_in, mod_in);
         expected_powers = {expected_powers, want};
      endfunction

      function void check_response(input logic [FIELD_WIDTH-1:0] power_in,
                                   input logic                   bad_in);
         power_word_type want;
         if (expected_powers.size() == 0) begin
            $error("response word with none expected: power_result %h bad_modulus %b",
                   power_in, bad_in);
            error_count++;
            return;
         end
         want = expected_powers.pop_front();
         if (power_in !== want.power) begin
            $error("power_result: expected %h, actual %h", want.power, power_in);
            error_count++;
         end
         if (bad_in !== want.bad) begin
            $error("bad_modulus: expected %b, actual %b", want.bad, bad_in);
            error_count++;
         end
      endfunction

      function int pending_count();
         return expected_powers.size();
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [FIELD_WIDTH-1:0] req_base_value;
   logic [FIELD_WIDTH-1:0] req_exponent_value;
   logic [FIELD_WIDTH-1:0] req_modulus_value;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [FIELD_WIDTH-1:0] rsp_power_result;
   logic                   rsp_bad_modulus;

   power_scoreboard sb;
   bit              idling_on;
   bit              hold_off_request;
   bit              hold_active;

   modular_exponentiation_unit dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_base_value     (req_base_value),
      .req_exponent_value (req_exponent_value),
      .req_modulus_value  (req_modulus_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_power_result   (rsp_power_result),
      .rsp_bad_modulus    (rsp_bad_modulus)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #30_000_000;
      $display("FAIL modular_exponentiation_unit");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_response(rsp_power_result, rsp_bad_modulus);
   end

   // offer one word and hold it until taken, valid is left high unless idling drops it
   task automatic send_word(input logic [FIELD_WIDTH-1:0] base_in,
                            input logic [FIELD_WIDTH-1:0] exp_in,
                            input logic [FIELD_WIDTH-1:0] mod_in);
      req_valid          <= 1'b1;
      req_base_value     <= base_in;
      req_exponent_value <= exp_in;
      req_modulus_value  <= mod_in;
      do @(posedge clock); while (!req_ready);
      sb.note_request(base_in, exp_in, mod_in);
      if (idling_on && $urandom_range(0, 2) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.pending_count() != 0)
         @(posedge clock);
   endtask

   // response side: random stall bursts, plus one long hold-off on request
   initial begin : receiver
      rsp_ready <= 1'b0;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         if (hold_off_request) begin
            rsp_ready   <= 1'b0;
            hold_active = 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_request = 1'b0;
            hold_active      = 1'b0;
         end else if (idling_on && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end else if (idling_on) begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      logic [FIELD_WIDTH-1:0] b;
      logic [FIELD_WIDTH-1:0] e;
      logic [FIELD_WIDTH-1:0] m;
      int                     pick;
      int                     n;
      sb               = new();
      idling_on        = 1'b1;
      hold_off_request = 1'b0;
      hold_active      = 1'b0;
      reset              <= 1'b1;
      req_valid          <= 1'b0;
      req_base_value     <= '0;
      req_exponent_value <= '0;
      req_modulus_value  <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero modulus wins over everything, even a zero exponent
      send_word(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
      send_word(32'h0000_0000, 32'h0000_0001, 32'h0000_0000);
      // zero exponent gives one, modulus of one included
      send_word(32'h0000_0005, 32'h0000_0000, 32'h0000_0001);
      send_word(32'h0000_0000, 32'h0000_0000, 32'h0000_0007);
      send_word(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
      // modulus of one with a live exponent, then small moduli
      send_word(32'h0000_0007, 32'h0000_0005, 32'h0000_0001);
      send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001);
      send_word(32'h0000_0000, 32'h0000_0005, 32'h0000_000D);
      send_word(32'h0000_0002, 32'h0000_000A, 32'h0000_03E8);
      // base at, below or above the modulus
      send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_word(32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
      send_word(32'h1234_5678, 32'h0000_0001, 32'h0000_03E8);
      send_word(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0002);
      send_word(32'h0000_0003, 32'hFFFF_FFFF, 32'hFFFF_FFFB);
      send_word(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAB);
      send_word(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5557);
      send_word(32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0007);
      send_word(32'h075B_CD15, 32'h3ADE_68B1, 32'hFFFF_FFFB);
      wait_drained();

      // long response stall while words keep coming, so req side backs up
      idling_on        = 1'b0;
      hold_off_request = 1'b1;
      while (!hold_active)
         @(posedge clock);
      send_word(32'h0000_0009, 32'h0000_0000, 32'h0000_0011);
      send_word(32'hDEAD_BEEF, 32'h0000_0003, 32'h0000_0000);
      send_word(32'h0000_0004, 32'h0000_0007, 32'h0000_0001);
      send_word($urandom, $urandom, $urandom | 32'h1);
      wait_drained();
      idling_on = 1'b1;

      for (n = 0; n < RANDOM_WORDS; n++) begin
         if (n == RANDOM_WORDS - CALM_WORDS)
            idling_on = 1'b0;
         b    = $urandom;
         e    = $urandom;
         m    = $urandom;
         pick = $urandom_range(0, 99);
         if (pick < 5) begin
            m = '0;
            if ($urandom_range(0, 1) == 0)
               e = '0;
         end else if (pick < 12) begin
            e = '0;
            if ($urandom_range(0, 1) == 0)
               m = 32'h1;
         end else if (pick < 18) begin
            m = 32'h1;
         end else if (pick < 32) begin
            m = $urandom_range(2, 255);
         end else if (pick < 42) begin
            m = 32'hFFFF_FFFF - $urandom_range(0, 1000);
         end else if (pick < 50) begin
            e = 32'h1 << $urandom_range(0, 31);
         end else if (pick < 56) begin
            // base one below the modulus
            m = m | 32'h2;
            b = m - 32'h1;
         end
         send_word(b, e, m);
      end
      wait_drained();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.pending_count() != 0) begin
         $error("%0d response words never arrived", sb.pending_count());
         sb.error_count++;
      end
      if (sb.error_count == 0)
         $display("PASS modular_exponentiation_unit");
      else
         $display("FAIL modular_exponentiation_unit");
      $finish;
   end

endmodule
